// ===== hw/rtl/lagrange_coeff_mod_l_macros.svh =====
// Assertion macros shared by the Lagrange coefficient RTL.
// Needs a clock named clock and a synchronous reset named reset in the using module.
`ifndef LAGRANGE_COEFF_MOD_L_MACROS_SVH
`define LAGRANGE_COEFF_MOD_L_MACROS_SVH
`ifndef SYNTHESIS
`define LCM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcm assertion failed");
`define LCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcm assertion failed");
`else
`define LCM_ASSERT_SAME(label, ante, cons)
`define LCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/lcm_pkg.sv =====
// Package for the Lagrange coefficient block: widths, group order constants and types.
// Depends on nothing; used by lcm_modmul and lagrange_coeff_mod_l.
`timescale 1ns / 1ps
package lcm_pkg;
   localparam int WORD_BITS = 64;
   localparam int LIMBS     = 4;
   localparam int VAL_BITS  = WORD_BITS * LIMBS;
   localparam int EXP_BITS  = 253;
   localparam int IDX_BITS  = 8;
   localparam int CNT_BITS  = 8;

   typedef logic [LIMBS-1:0][WORD_BITS-1:0] value_type;

   localparam logic [VAL_BITS-1:0] GROUP_ORDER =
      256'h1000000000000000_0000000000000000_14def9dea2f79cd6_5812631a5cf5d3ed;
   localparam logic [VAL_BITS-1:0] ORDER_MINUS_TWO =
      256'h1000000000000000_0000000000000000_14def9dea2f79cd6_5812631a5cf5d3eb;
   localparam logic [VAL_BITS-1:0] VALUE_ONE = 256'd1;

   typedef enum logic [1:0] {
      MM_IDLE,
      MM_DBL,
      MM_ADD
   } mm_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUM,
      ST_DEN,
      ST_INV_LOAD,
      ST_INV_MUL,
      ST_INV_SQR,
      ST_LAMBDA,
      ST_OUT
   } lcm_state_type;

   typedef struct packed {
      logic      start;
      value_type op_a;
      value_type op_b;
   } mm_req_type;
endpackage

// ===== hw/rtl/lcm_modmul.sv =====
// Iterative modular multiplier mod the group order, one shared add-and-reduce unit.
// Depends on lcm_pkg.
`timescale 1ns / 1ps
module lcm_modmul import lcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  mm_req_type mm_req,
   output logic       mm_done,
   output value_type  mm_product
);
   mm_state_type          state_ff, state_in;
   value_type             acc_ff, acc_in;
   value_type             a_ff, a_in;
   logic [VAL_BITS-1:0]   b_ff, b_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [VAL_BITS-1:0]   add_y;
   logic [VAL_BITS:0]     sum;
   logic [VAL_BITS:0]     dif;
   logic [VAL_BITS-1:0]   red;
   logic                  last_bit;

   // Shared unit: (acc + y) mod l for operands below l.
   assign add_y = (state_ff == MM_ADD) ? a_ff : acc_ff;
   assign sum   = {1'b0, acc_ff} + {1'b0, add_y};
   assign dif   = sum - {1'b0, GROUP_ORDER};
   assign red   = dif[VAL_BITS] ? sum[VAL_BITS-1:0] : dif[VAL_BITS-1:0];
   assign last_bit = (cnt_ff == CNT_BITS'(VAL_BITS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) state_in = MM_DBL;
         end
         MM_DBL: begin
            if (b_ff[VAL_BITS-1]) state_in = MM_ADD;
            else if (last_bit)    state_in = MM_IDLE;
         end
         MM_ADD: begin
            state_in = last_bit ? MM_IDLE : MM_DBL;
         end
         default: state_in = MM_IDLE;
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               acc_in = '0;
               a_in   = mm_req.op_a;
               b_in   = mm_req.op_b;
               cnt_in = '0;
            end
         end
         MM_DBL: begin
            acc_in = red;
            if (!b_ff[VAL_BITS-1]) begin
               b_in    = b_ff << 1;
               cnt_in  = cnt_ff + CNT_BITS'(1);
               done_in = last_bit;
            end
         end
         MM_ADD: begin
            acc_in  = red;
            b_in    = b_ff << 1;
            cnt_in  = cnt_ff + CNT_BITS'(1);
            done_in = last_bit;
         end
         default: done_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign mm_done    = done_ff;
   assign mm_product = acc_ff;
endmodule

// ===== hw/rtl/lagrange_coeff_mod_l.sv =====
// An index other than the own index costs two modular multiplications, each with a doubling
// step per multiplier bit and an add step per set bit of the multiplier operand. The own
// index costs no multiplication. The last index adds 253 squarings, one multiply per set
// exponent bit (73) and a final multiply.
// Four result beats follow; no new index is taken until the last one is delivered.
// Synchronous active-high reset; own index resets to one, products to one.
`timescale 1ns / 1ps
`include "lagrange_coeff_mod_l_macros.svh"
module lagrange_coeff_mod_l import lcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [IDX_BITS-1:0]  req_signer_index,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_lambda_word,
   output logic [1:0]           rsp_word_number,
   output logic                 rsp_final_word,
   output logic                 rsp_set_valid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_BITS-1:0]  csr_own_index
);
   // Sequencer state and the flag that says the current multiply is launched.
   lcm_state_type          state_ff, state_in;
   logic                   issued_ff, issued_in;

   // Configuration and set bookkeeping.
   logic [IDX_BITS-1:0]    own_ff, own_in;
   logic [(1<<IDX_BITS)-1:0] seen_ff, seen_in;
   logic                   own_found_ff, own_found_in;
   logic                   fault_ff, fault_in;
   logic                   last_ff, last_in;

   // Working values.
   value_type              num_ff, num_in;
   value_type              den_ff, den_in;
   value_type              base_ff, base_in;
   value_type              accp_ff, accp_in;
   value_type              lam_ff, lam_in;
   value_type              j_ff, j_in;
   value_type              diff_ff, diff_in;
   logic [CNT_BITS-1:0]    exp_cnt_ff, exp_cnt_in;
   logic [1:0]             word_ff, word_in;
   logic                   valid_ff, valid_in;

   logic                   in_beat;
   logic                   out_beat;
   logic                   is_mul_state;
   logic [CNT_BITS-1:0]    exp_next;
   logic                   exp_last;
   mm_req_type             mm_req;
   logic                   mm_done;
   value_type              mm_product;

   assign csr_ready    = 1'b1;
   assign in_beat      = req_valid && req_ready;
   assign out_beat     = rsp_valid && rsp_ready;
   assign exp_next     = exp_cnt_ff + CNT_BITS'(1);
   assign exp_last     = (exp_cnt_ff == CNT_BITS'(EXP_BITS - 1));
   assign is_mul_state = (state_ff == ST_NUM) || (state_ff == ST_DEN) ||
                         (state_ff == ST_INV_MUL) || (state_ff == ST_INV_SQR) ||
                         (state_ff == ST_LAMBDA);

   // The multiplier starts on entry to each multiply state and for each further squaring.
   always_comb begin
      mm_req.start = is_mul_state && !issued_ff;
      mm_req.op_a  = num_ff;
      mm_req.op_b  = j_ff;
      case (state_ff)
         ST_NUM: begin
            mm_req.op_a = num_ff;
            mm_req.op_b = j_ff;
         end
         ST_DEN: begin
            mm_req.op_a = den_ff;
            mm_req.op_b = diff_ff;
         end
         ST_INV_MUL: begin
            mm_req.op_a = accp_ff;
            mm_req.op_b = base_ff;
         end
         ST_INV_SQR: begin
            mm_req.op_a = base_ff;
            mm_req.op_b = base_ff;
         end
         ST_LAMBDA: begin
            mm_req.op_a = num_ff;
            mm_req.op_b = accp_ff;
         end
         default: mm_req.op_a = num_ff;
      endcase
   end

   lcm_modmul u_modmul (
      .clock      (clock),
      .reset      (reset),
      .mm_req     (mm_req),
      .mm_done    (mm_done),
      .mm_product (mm_product)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               if (req_signer_index != own_ff) state_in = ST_NUM;
               else if (req_last)              state_in = ST_INV_LOAD;
            end
         end
         ST_NUM: begin
            if (mm_done) state_in = ST_DEN;
         end
         ST_DEN: begin
            if (mm_done) state_in = last_ff ? ST_INV_LOAD : ST_IDLE;
         end
         ST_INV_LOAD: begin
            state_in = ORDER_MINUS_TWO[exp_cnt_ff] ? ST_INV_MUL : ST_INV_SQR;
         end
         ST_INV_MUL: begin
            if (mm_done) state_in = ST_INV_SQR;
         end
         ST_INV_SQR: begin
            if (mm_done) begin
               if (exp_last)                        state_in = ST_LAMBDA;
               else if (ORDER_MINUS_TWO[exp_next]) state_in = ST_INV_MUL;
            end
         end
         ST_LAMBDA: begin
            if (mm_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_beat && (word_ff == 2'd3)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs depend on the state alone.
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      rsp_valid       = (state_ff == ST_OUT);
      rsp_lambda_word = lam_ff[word_ff];
      rsp_word_number = word_ff;
      rsp_final_word  = (word_ff == 2'd3);
      rsp_set_valid   = valid_ff;
   end

   // Data path updates.
   always_comb begin
      own_in       = csr_valid ? csr_own_index : own_ff;
      seen_in      = seen_ff;
      own_found_in = own_found_ff;
      fault_in     = fault_ff;
      last_in      = last_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      base_in      = base_ff;
      accp_in      = accp_ff;
      lam_in       = lam_ff;
      j_in         = j_ff;
      diff_in      = diff_ff;
      exp_cnt_in   = exp_cnt_ff;
      word_in      = word_ff;
      valid_in     = valid_ff;
      issued_in    = mm_req.start ? 1'b1 : (mm_done ? 1'b0 : issued_ff);
      case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               last_in = req_last;
               j_in    = VAL_BITS'(req_signer_index);
               // Difference j - i mod l; i - j is small so l - (i - j) stays in range.
               if (req_signer_index >= own_ff)
                  diff_in = VAL_BITS'(req_signer_index - own_ff);
               else
                  diff_in = GROUP_ORDER - VAL_BITS'(own_ff - req_signer_index);
               if (req_signer_index == '0) begin
                  fault_in = 1'b1;
               end else begin
                  if (seen_ff[req_signer_index]) fault_in = 1'b1;
                  seen_in[req_signer_index] = 1'b1;
                  if (req_signer_index == own_ff) own_found_in = 1'b1;
               end
            end
         end
         ST_NUM: begin
            if (mm_done) num_in = mm_product;
         end
         ST_DEN: begin
            if (mm_done) den_in = mm_product;
         end
         ST_INV_LOAD: begin
            base_in    = den_ff;
            accp_in    = VALUE_ONE;
            exp_cnt_in = '0;
         end
         ST_INV_MUL: begin
            if (mm_done) accp_in = mm_product;
         end
         ST_INV_SQR: begin
            if (mm_done) begin
               base_in    = mm_product;
               exp_cnt_in = exp_last ? '0 : exp_next;
            end
         end
         ST_LAMBDA: begin
            if (mm_done) begin
               lam_in   = mm_product;
               valid_in = own_found_ff && !fault_ff;
               word_in  = '0;
            end
         end
         ST_OUT: begin
            if (out_beat) begin
               word_in = word_ff + 2'd1;
               if (word_ff == 2'd3) begin
                  // The set is finished: products back to one, map and flags clear.
                  num_in       = VALUE_ONE;
                  den_in       = VALUE_ONE;
                  seen_in      = '0;
                  own_found_in = 1'b0;
                  fault_in     = 1'b0;
               end
            end
         end
         default: issued_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         own_ff       <= IDX_BITS'(1);
         seen_ff      <= '0;
         own_found_ff <= 1'b0;
         fault_ff     <= 1'b0;
         num_ff       <= VALUE_ONE;
         den_ff       <= VALUE_ONE;
         exp_cnt_ff   <= '0;
         word_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         own_ff       <= own_in;
         seen_ff      <= seen_in;
         own_found_ff <= own_found_in;
         fault_ff     <= fault_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         exp_cnt_ff   <= exp_cnt_in;
         word_ff      <= word_in;
      end
      last_ff  <= last_in;
      base_ff  <= base_in;
      accp_ff  <= accp_in;
      lam_ff   <= lam_in;
      j_ff     <= j_in;
      diff_ff  <= diff_in;
      valid_ff <= valid_in;
   end

   // Input and result sides are never open together.
   `LCM_ASSERT_SAME(a_sides_exclusive, req_ready, !rsp_valid)
   // Result words leave in order.
   `LCM_ASSERT_NEXT(a_word_order, out_beat && !rsp_final_word, rsp_word_number == $past(rsp_word_number) + 2'd1)
   // After the last word the block is ready again with a cleared set.
   `LCM_ASSERT_NEXT(a_set_cleared, out_beat && rsp_final_word, req_ready && !own_found_ff && !fault_ff)
endmodule
